// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the calendar clock counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/cal_pkg.sv -----
// Types, constants and the month-length function of the calendar clock counter.
package cal_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  localparam logic [5:0] SEC_LAST     = 6'd59;
  localparam logic [5:0] MIN_LAST     = 6'd59;
  localparam logic [4:0] HOUR_LAST    = 5'd23;
  localparam logic [2:0] WEEKDAY_LAST = 3'd6;
  localparam logic [3:0] MONTH_LAST   = 4'd12;
  localparam logic [6:0] YEAR_LAST    = 7'd99;
  localparam logic [4:0] DAY_FIRST    = 5'd1;
  localparam logic [3:0] MONTH_FIRST  = 4'd1;
  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [4:0] DAYS_FEB     = 5'd28;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAYS_SHORT   = 5'd30;
  localparam logic [4:0] DAYS_LONG    = 5'd31;

  typedef struct packed {
    op_t        operation;
    logic [5:0] load_second;
    logic [5:0] load_minute;
    logic [4:0] load_hour;
    logic [4:0] load_day;
    logic [2:0] load_weekday;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } req_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [3:0] month;
    logic [6:0] year;
    logic       leap_year;
  } res_t;

  // Length of a month; codes outside one to twelve count as 31 days.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      case (month)
        4'd2: begin
          len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
        end
        4'd4, 4'd6, 4'd9, 4'd11: begin
          len = DAYS_SHORT;
        end
        default: begin
          len = DAYS_LONG;
        end
      endcase
      return len;
    end
  endfunction

endpackage

// ----- rtl/calendar_clock_counter.sv -----
// Top level of the calendar clock counter: counters, carry chain and result buffer.
//
//   Channel   Signals                       Direction  Moves
//   request   req_valid, req_ready, req     in         one tick or one load of all fields
//   result    res_valid, res_ready, res     out        date and time after each request
//
// The counters update at the edge that accepts a request; its result is registered
// in the output register, or in the skid register while an earlier result waits.
// A new request can be taken every cycle while the skid register is empty. The
// tick/load selection and the carry chain from seconds to year are the logic between
// the counter registers and the result register. Reset sets the time to 00:00:00 on
// day 1, month 1, year 0, weekday 0, and empties the result buffer. Its two entries
// keep accepting while one result waits; req_ready comes straight from the skid register.
module calendar_clock_counter (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cal_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output cal_pkg::res_t res
);
  import cal_pkg::*;

  `include "assert_macros.svh"

  // Calendar counters.
  logic [5:0] sec_count;
  logic [5:0] min_count;
  logic [4:0] hour_count;
  logic [4:0] day_count;
  logic [2:0] weekday_count;
  logic [3:0] month_count;
  logic [6:0] year_count;

  logic [5:0] sec_count_next;
  logic [5:0] min_count_next;
  logic [4:0] hour_count_next;
  logic [4:0] day_count_next;
  logic [2:0] weekday_count_next;
  logic [3:0] month_count_next;
  logic [6:0] year_count_next;

  // Result buffer: the output register and one skid entry behind it.
  logic res_valid_q;
  res_t res_q;
  logic skid_valid;
  res_t skid_q;

  logic req_fire;
  logic res_fire;
  logic leap_now;
  logic [4:0] days_now;
  logic carry_sec;
  logic carry_min;
  logic carry_hour;
  logic carry_day;
  logic carry_month;
  res_t res_new;

  assign req_ready = !skid_valid;
  assign req_fire  = req_valid && req_ready;
  assign res_fire  = res_valid_q && res_ready;
  assign res_valid = res_valid_q;
  assign res       = res_q;

  // February length follows the year currently held in the counters.
  assign leap_now = (year_count[1:0] == 2'd0);
  assign days_now = month_days(month_count, leap_now);

  // Each counter wraps once it is at or past its last value, so an
  // out-of-range load still rolls over on the next carry into it.
  assign carry_sec   = (sec_count >= SEC_LAST);
  assign carry_min   = carry_sec && (min_count >= MIN_LAST);
  assign carry_hour  = carry_min && (hour_count >= HOUR_LAST);
  assign carry_day   = carry_hour && (day_count >= days_now);
  assign carry_month = carry_day && (month_count >= MONTH_LAST);

  always_comb begin
    if (req.operation == OP_LOAD) begin
      sec_count_next     = req.load_second;
      min_count_next     = req.load_minute;
      hour_count_next    = req.load_hour;
      day_count_next     = req.load_day;
      weekday_count_next = req.load_weekday;
      month_count_next   = req.load_month;
      year_count_next    = req.load_year;
    end else begin
      sec_count_next  = carry_sec ? 6'd0 : sec_count + 6'd1;
      min_count_next  = min_count;
      hour_count_next = hour_count;
      day_count_next  = day_count;
      weekday_count_next = weekday_count;
      month_count_next   = month_count;
      year_count_next    = year_count;
      if (carry_sec) begin
        min_count_next = carry_min ? 6'd0 : min_count + 6'd1;
      end
      if (carry_min) begin
        hour_count_next = carry_hour ? 5'd0 : hour_count + 5'd1;
      end
      // A day carry moves weekday and day of month together; a day of zero
      // simply steps to one, since it is below any month length.
      if (carry_hour) begin
        weekday_count_next = (weekday_count >= WEEKDAY_LAST) ? 3'd0 : weekday_count + 3'd1;
        day_count_next     = carry_day ? DAY_FIRST : day_count + 5'd1;
      end
      if (carry_day) begin
        month_count_next = carry_month ? MONTH_FIRST : month_count + 4'd1;
      end
      if (carry_month) begin
        year_count_next = (year_count >= YEAR_LAST) ? 7'd0 : year_count + 7'd1;
      end
    end
  end

  always_comb begin
    res_new.second    = sec_count_next;
    res_new.minute    = min_count_next;
    res_new.hour      = hour_count_next;
    res_new.day       = day_count_next;
    res_new.weekday   = weekday_count_next;
    res_new.month     = month_count_next;
    res_new.year      = year_count_next;
    res_new.leap_year = (year_count_next[1:0] == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_count     <= 6'd0;
      min_count     <= 6'd0;
      hour_count    <= 5'd0;
      day_count     <= DAY_FIRST;
      weekday_count <= 3'd0;
      month_count   <= MONTH_FIRST;
      year_count    <= 7'd0;
    end else if (req_fire) begin
      sec_count     <= sec_count_next;
      min_count     <= min_count_next;
      hour_count    <= hour_count_next;
      day_count     <= day_count_next;
      weekday_count <= weekday_count_next;
      month_count   <= month_count_next;
      year_count    <= year_count_next;
    end
  end

  // Result buffer control. The output register refills whenever it is empty
  // or being drained, taking the skid entry first so results stay in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (!res_valid_q || res_fire) begin
        res_valid_q <= skid_valid || req_fire;
        skid_valid  <= 1'b0;
      end else if (req_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid_q || res_fire) begin
      res_q <= skid_valid ? skid_q : res_new;
    end
    if (req_fire && res_valid_q && !res_fire) begin
      skid_q <= res_new;
    end
  end

  // The skid entry is only ever filled behind a waiting result.
  `ASSERT_IMPL(a_skid_behind_out, skid_valid, res_valid_q)
  // A load takes the counters as given, checked on the seconds and the year.
  `ASSERT_NEXT(a_load_taken, req_fire && req.operation == OP_LOAD,
               sec_count == $past(req.load_second) && year_count == $past(req.load_year))
  // A tick below the last second only advances the seconds.
  `ASSERT_NEXT(a_tick_seconds, req_fire && req.operation == OP_TICK && sec_count < SEC_LAST,
               sec_count == $past(sec_count) + 6'd1 && $stable(min_count))
  // A result waiting on a stalled consumer is neither dropped nor altered.
  `ASSERT_NEXT(a_result_held, res_valid_q && !res_ready, res_valid_q && $stable(res_q))

endmodule
